// ===== design/cpa_pkg.sv =====
// shared types and constants of the contiguous page allocator
package cpa_pkg;

    localparam int CMD_W  = 2;
    localparam int PID_W  = 16;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int PAGE_W = 10;
    localparam int STAT_W = 3;
    // page positions and sums of run lengths; a run ends at most at 2047
    localparam int POS_W  = 12;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_XLATE = 2'd2
    } cmd_e;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_UNKNOWN   = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_RANGE     = 3'd4,
        ST_BAD       = 3'd5
    } status_e;

    typedef struct packed {
        logic capture;
        logic scan_step;
        logic finish;
        logic fit_clear;
        logic fit_load;
        logic cand_zero;
        logic fit_eval;
        logic alloc_commit;
        logic alloc_fail;
        logic row_start;
        logic cmp_step;
        logic cmp_store;
        logic cmp_commit;
        logic out_load;
    } cpa_ctl_t;

    typedef struct packed {
        logic need_fit;
        logic fit_found;
        logic compacted;
    } cpa_sts_t;

endpackage

// ===== design/cpa_if.sv =====
// request, response and configuration channels of the page allocator
interface cpa_req_if import cpa_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [PID_W-1:0]   process_id;
    logic [CNT_W-1:0]   page_count;
    logic [IDX_W-1:0]   page_index;

    modport source (output valid, command, process_id, page_count, page_index,
                    input ready);
    modport sink   (input valid, command, process_id, page_count, page_index,
                    output ready);
endinterface

interface cpa_rsp_if import cpa_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [PAGE_W-1:0]   base_page;
    logic [PAGE_W-1:0]   physical_page;
    logic                compacted;

    modport source (output valid, status, base_page, physical_page, compacted,
                    input ready);
    modport sink   (input valid, status, base_page, physical_page, compacted,
                    output ready);
endinterface

interface cpa_cfg_if import cpa_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CNT_W-1:0]   total_pages;

    modport source (output valid, total_pages, input ready);
    modport sink   (input valid, total_pages, output ready);
endinterface

// ===== design/cpa_datapath.sv =====
// segment table, scan accumulators, first-fit search and compaction datapath
module cpa_datapath import cpa_pkg::*; #(
    parameter int MAX_PAGES = 1024,
    parameter int MAX_PROCS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cpa_ctl_t                      ctl,
    input  logic [$clog2(MAX_PROCS)-1:0]  idx,
    output cpa_sts_t                      sts,
    input  logic                          cfg_we,
    input  logic [CNT_W-1:0]              cfg_total,
    input  logic [CMD_W-1:0]              command,
    input  logic [PID_W-1:0]              process_id,
    input  logic [CNT_W-1:0]              page_count,
    input  logic [IDX_W-1:0]              page_index,
    output logic [STAT_W-1:0]             status,
    output logic [PAGE_W-1:0]             base_page,
    output logic [PAGE_W-1:0]             physical_page,
    output logic                          compacted
);

    localparam int SW  = $clog2(MAX_PROCS);
    localparam int CAP = (MAX_PAGES > 2047) ? 2047 : MAX_PAGES;
    localparam logic [POS_W-1:0] AREA_CAP = POS_W'(CAP);

    // segment table
    logic [MAX_PROCS-1:0]  ent_valid_reg;
    logic [PID_W-1:0]      ent_pid_reg  [MAX_PROCS];
    logic [POS_W-1:0]      ent_base_reg [MAX_PROCS];
    logic [CNT_W-1:0]      ent_cnt_reg  [MAX_PROCS];
    logic [POS_W-1:0]      new_base_reg [MAX_PROCS];

    logic [CNT_W-1:0]  total_reg;
    logic [CMD_W-1:0]  req_cmd_reg;
    logic [PID_W-1:0]  req_pid_reg;
    logic [CNT_W-1:0]  req_cnt_reg;
    logic [IDX_W-1:0]  req_idx_reg;

    logic              found_reg;
    logic [SW-1:0]     slot_reg;
    logic [POS_W-1:0]  found_base_reg;
    logic [CNT_W-1:0]  found_cnt_reg;
    logic              empty_found_reg;
    logic [SW-1:0]     empty_reg;
    logic [POS_W-1:0]  used_reg;

    logic [POS_W-1:0]  cand_reg;
    logic              cand_ok_reg;
    logic              best_found_reg;
    logic [POS_W-1:0]  best_reg;
    logic              compacted_reg;

    logic [POS_W-1:0]  cur_base_reg;
    logic [POS_W-1:0]  acc_reg;

    logic [STAT_W-1:0] res_status_reg;
    logic [PAGE_W-1:0] res_base_reg;
    logic [PAGE_W-1:0] res_phys_reg;
    logic              res_comp_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic [PAGE_W-1:0] out_base_reg;
    logic [PAGE_W-1:0] out_phys_reg;
    logic              out_comp_reg;

    logic              rd_valid;
    logic [PID_W-1:0]  rd_pid;
    logic [POS_W-1:0]  rd_base;
    logic [CNT_W-1:0]  rd_cnt;
    logic [POS_W-1:0]  rd_end;
    logic [POS_W-1:0]  area;
    logic [POS_W-1:0]  avail;
    logic [POS_W-1:0]  need;
    logic [POS_W-1:0]  cand_hi;
    logic [MAX_PROCS-1:0] ovl;
    logic              fits;
    logic              scan_hit;
    status_e           dec_status;
    logic              dec_fit;

    assign rd_valid = ent_valid_reg[idx];
    assign rd_pid   = ent_pid_reg[idx];
    assign rd_base  = ent_base_reg[idx];
    assign rd_cnt   = ent_cnt_reg[idx];
    assign rd_end   = rd_base + POS_W'(rd_cnt);

    assign area  = (POS_W'(total_reg) > AREA_CAP) ? AREA_CAP : POS_W'(total_reg);
    assign avail = (area > used_reg) ? (area - used_reg) : '0;

    assign need    = POS_W'(req_cnt_reg);
    assign cand_hi = cand_reg + need;

    // candidate overlaps a run: all runs checked side by side
    always_comb
    begin
        for (int j = 0; j < MAX_PROCS; j++)
        begin
            ovl[j] = ent_valid_reg[j] && (ent_base_reg[j] < cand_hi)
                     && (cand_reg < ent_base_reg[j] + POS_W'(ent_cnt_reg[j]));
        end
    end

    assign fits     = cand_ok_reg && (cand_hi <= area) && (ovl == '0);
    assign scan_hit = rd_valid && (rd_pid == req_pid_reg) && !found_reg;

    always_comb
    begin
        dec_status = ST_OK;
        dec_fit    = 1'b0;
        case (req_cmd_reg)
            CMD_ALLOC:
            begin
                if (req_cnt_reg == '0)
                    dec_status = ST_BAD;
                else if (found_reg)
                    dec_status = ST_DUPLICATE;
                else if (!empty_found_reg)
                    dec_status = ST_BAD;
                else if (need > avail)
                    dec_status = ST_NO_SPACE;
                else
                    dec_fit = 1'b1;
            end
            CMD_FREE:
            begin
                if (!found_reg)
                    dec_status = ST_UNKNOWN;
            end
            CMD_XLATE:
            begin
                if (!found_reg)
                    dec_status = ST_UNKNOWN;
                else if ({1'b0, req_idx_reg} >= found_cnt_reg)
                    dec_status = ST_RANGE;
            end
            default:
                dec_status = ST_BAD;
        endcase
    end

    assign sts.need_fit  = dec_fit;
    assign sts.fit_found = best_found_reg;
    assign sts.compacted = compacted_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg   <= '0;
            total_reg       <= TOTAL_RESET;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            compacted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                total_reg <= cfg_total;
            if (ctl.capture)
            begin
                found_reg       <= 1'b0;
                empty_found_reg <= 1'b0;
                compacted_reg   <= 1'b0;
            end
            if (ctl.scan_step)
            begin
                if (scan_hit)
                    found_reg <= 1'b1;
                if (!rd_valid)
                    empty_found_reg <= 1'b1;
            end
            if (ctl.finish && dec_status == ST_OK && req_cmd_reg == CMD_FREE)
                ent_valid_reg[slot_reg] <= 1'b0;
            if (ctl.fit_clear)
                best_found_reg <= 1'b0;
            if (ctl.fit_eval && fits)
                best_found_reg <= 1'b1;
            if (ctl.alloc_commit)
                ent_valid_reg[empty_reg] <= 1'b1;
            if (ctl.cmp_commit)
                compacted_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_cmd_reg <= command;
            req_pid_reg <= process_id;
            req_cnt_reg <= page_count;
            req_idx_reg <= page_index;
            used_reg    <= '0;
        end
        if (ctl.scan_step)
        begin
            if (scan_hit)
            begin
                slot_reg       <= idx;
                found_base_reg <= rd_base;
                found_cnt_reg  <= rd_cnt;
            end
            if (!rd_valid && !empty_found_reg)
                empty_reg <= idx;
            if (rd_valid)
                used_reg <= used_reg + POS_W'(rd_cnt);
        end
        if (ctl.finish)
        begin
            res_status_reg <= dec_status;
            res_comp_reg   <= 1'b0;
            res_base_reg   <= (dec_status == ST_OK) ? found_base_reg[PAGE_W-1:0] : '0;
            res_phys_reg   <= (dec_status == ST_OK && req_cmd_reg == CMD_XLATE)
                              ? found_base_reg[PAGE_W-1:0] + PAGE_W'(req_idx_reg) : '0;
        end
        if (ctl.fit_load)
        begin
            cand_reg    <= ctl.cand_zero ? '0 : rd_end;
            cand_ok_reg <= ctl.cand_zero || rd_valid;
        end
        // candidates arrive unordered, keep the lowest that fits
        if (ctl.fit_eval && fits && (!best_found_reg || cand_reg < best_reg))
            best_reg <= cand_reg;
        if (ctl.alloc_commit)
        begin
            ent_pid_reg[empty_reg]  <= req_pid_reg;
            ent_base_reg[empty_reg] <= best_reg;
            ent_cnt_reg[empty_reg]  <= req_cnt_reg;
            res_status_reg <= ST_OK;
            res_base_reg   <= best_reg[PAGE_W-1:0];
            res_phys_reg   <= '0;
            res_comp_reg   <= compacted_reg;
        end
        if (ctl.alloc_fail)
        begin
            res_status_reg <= ST_NO_SPACE;
            res_base_reg   <= '0;
            res_phys_reg   <= '0;
            res_comp_reg   <= 1'b0;
        end
        // new base of a run is the length of all runs below it
        if (ctl.row_start)
        begin
            cur_base_reg <= rd_base;
            acc_reg      <= '0;
        end
        if (ctl.cmp_step && rd_valid && rd_base < cur_base_reg)
            acc_reg <= acc_reg + POS_W'(rd_cnt);
        if (ctl.cmp_store)
            new_base_reg[idx] <= acc_reg;
        if (ctl.cmp_commit)
        begin
            for (int j = 0; j < MAX_PROCS; j++)
            begin
                if (ent_valid_reg[j])
                    ent_base_reg[j] <= new_base_reg[j];
            end
        end
        if (ctl.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_base_reg   <= res_base_reg;
            out_phys_reg   <= res_phys_reg;
            out_comp_reg   <= res_comp_reg;
        end
    end

    assign status        = out_status_reg;
    assign base_page     = out_base_reg;
    assign physical_page = out_phys_reg;
    assign compacted     = out_comp_reg;

endmodule

// ===== design/cpa_ctrl.sv =====
// sequencer of table scan, first-fit search and compaction
module cpa_ctrl import cpa_pkg::*; #(
    parameter int MAX_PROCS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  cpa_sts_t                      sts,
    output cpa_ctl_t                      ctl,
    output logic [$clog2(MAX_PROCS)-1:0]  idx
);

    localparam int SW = $clog2(MAX_PROCS);
    localparam logic [SW:0]   LAST_K = (SW+1)'(MAX_PROCS - 1);
    localparam logic [SW:0]   FIT_K  = (SW+1)'(MAX_PROCS);
    localparam logic [SW-1:0] LAST_I = SW'(MAX_PROCS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_LOAD,
        S_EVAL,
        S_FITEND,
        S_CROW,
        S_CSUM,
        S_CSTORE,
        S_COMMIT,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    logic [SW:0]   k_reg, k_next;
    logic [SW-1:0] i_reg, i_next;
    logic          out_valid_reg, out_valid_next;
    logic [SW:0]   k_prev;

    assign k_prev = k_reg - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        out_valid_next = out_valid_reg;
        ctl            = '0;
        idx            = k_reg[SW-1:0];
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.capture = 1'b1;
                    k_next      = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (k_reg == LAST_K)
                    state_next = S_DECIDE;
                else
                    k_next = k_reg + 1'b1;
            end
            S_DECIDE:
            begin
                if (sts.need_fit)
                begin
                    ctl.fit_clear = 1'b1;
                    k_next        = '0;
                    state_next    = S_LOAD;
                end
                else
                begin
                    ctl.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_LOAD:
            begin
                // candidate zero is page 0, the others are ends of runs
                idx           = k_prev[SW-1:0];
                ctl.fit_load  = 1'b1;
                ctl.cand_zero = (k_reg == '0);
                state_next    = S_EVAL;
            end
            S_EVAL:
            begin
                ctl.fit_eval = 1'b1;
                if (k_reg == FIT_K)
                    state_next = S_FITEND;
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_FITEND:
            begin
                if (sts.fit_found)
                begin
                    ctl.alloc_commit = 1'b1;
                    state_next       = S_DONE;
                end
                else if (!sts.compacted)
                begin
                    i_next     = '0;
                    state_next = S_CROW;
                end
                else
                begin
                    ctl.alloc_fail = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_CROW:
            begin
                idx           = i_reg;
                ctl.row_start = 1'b1;
                k_next        = '0;
                state_next    = S_CSUM;
            end
            S_CSUM:
            begin
                ctl.cmp_step = 1'b1;
                if (k_reg == LAST_K)
                    state_next = S_CSTORE;
                else
                    k_next = k_reg + 1'b1;
            end
            S_CSTORE:
            begin
                idx           = i_reg;
                ctl.cmp_store = 1'b1;
                if (i_reg == LAST_I)
                    state_next = S_COMMIT;
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_CROW;
                end
            end
            S_COMMIT:
            begin
                ctl.cmp_commit = 1'b1;
                ctl.fit_clear  = 1'b1;
                k_next         = '0;
                state_next     = S_LOAD;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctl.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            i_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== design/contiguous_page_allocator.sv =====
// contiguous page allocator: first-fit run placement with compaction
//
// req carries one request beat (allocate, free or translate); rsp returns
// exactly one result beat per request, in order. cfg writes total_pages and
// is always ready; write it only while no request is in flight.
// A request is taken only while the sequencer is idle. Every request first
// scans the segment table, one entry a cycle, then decides; free and translate
// then hand over their result. An allocate that reaches placement adds a
// first-fit search over the candidates page 0 and each run end.
// When no gap fits, runs are compacted first, summing run lengths per entry,
// then the search is repeated.
// The result sits in an output register; while the receiver stalls, the next
// request is still taken and worked on, and waits only to hand over its
// result. Reset empties the table and sets total_pages to 1024.
module contiguous_page_allocator import cpa_pkg::*; #(
    parameter int MAX_PAGES = 1024,
    parameter int MAX_PROCS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    cpa_req_if.sink   req,
    cpa_rsp_if.source rsp,
    cpa_cfg_if.sink   cfg
);

    cpa_ctl_t                      ctl;
    cpa_sts_t                      sts;
    logic [$clog2(MAX_PROCS)-1:0]  idx;

    assign cfg.ready = 1'b1;

    cpa_ctrl #(
        .MAX_PROCS (MAX_PROCS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .ctl       (ctl),
        .idx       (idx)
    );

    cpa_datapath #(
        .MAX_PAGES (MAX_PAGES),
        .MAX_PROCS (MAX_PROCS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .idx           (idx),
        .sts           (sts),
        .cfg_we        (cfg.valid),
        .cfg_total     (cfg.total_pages),
        .command       (req.command),
        .process_id    (req.process_id),
        .page_count    (req.page_count),
        .page_index    (req.page_index),
        .status        (rsp.status),
        .base_page     (rsp.base_page),
        .physical_page (rsp.physical_page),
        .compacted     (rsp.compacted)
    );

    // one request at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    // errors carry no page numbers and no compaction flag
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |->
            rsp.base_page == '0 && rsp.physical_page == '0 && !rsp.compacted)
        else $error("error result with page fields set");

    // a translated page never comes with compaction
    a_xlate_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.physical_page != '0 |-> rsp.status == ST_OK && !rsp.compacted)
        else $error("physical page on a non-translate result");

endmodule

// ===== sim/cpa_scoreboard.sv =====
// scoreboard class: page allocator predictor and expected result store
`timescale 1ns / 100ps
package cpa_sb_pkg;
    import cpa_pkg::*;

    typedef struct {
        status_e          status;
        logic [PAGE_W-1:0] base_page;
        logic [PAGE_W-1:0] physical_page;
        logic             compacted;
    } alloc_result_t;

    typedef struct {
        bit        used;
        int unsigned pid;
        int unsigned base;
        int unsigned count;
    } run_t;

    class alloc_scoreboard;
        run_t          runs[16];
        int unsigned   total_pages;
        alloc_result_t pending[$];
        int            errors;
        int            results_seen;
        int            compactions;

        function new();
            foreach (runs[i]) runs[i].used = 0;
            total_pages = TOTAL_RESET;
            errors = 0;
            results_seen = 0;
            compactions = 0;
        endfunction

        function int unsigned area();
            return total_pages > 1024 ? 1024 : total_pages;
        endfunction

        function int find_run(int unsigned pid);
            for (int i = 0; i < 16; i++)
                if (runs[i].used && runs[i].pid == pid) return i;
            return -1;
        endfunction

        // slots ordered by base, ties by slot number
        function void order_runs(ref int ord[16], ref int n);
            int j;
            n = 0;
            for (int i = 0; i < 16; i++) begin
                if (!runs[i].used) continue;
                j = n;
                while (j > 0 && runs[ord[j-1]].base > runs[i].base) begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = i;
                n++;
            end
        endfunction

        function bit fit_gap(int unsigned need, ref int unsigned where);
            int ord[16];
            int n;
            int unsigned lim, cur, ge;
            order_runs(ord, n);
            lim = area();
            cur = 0;
            for (int k = 0; k < n; k++) begin
                ge = runs[ord[k]].base < lim ? runs[ord[k]].base : lim;
                if (ge > cur && ge - cur >= need) begin
                    where = cur;
                    return 1;
                end
                if (runs[ord[k]].base + runs[ord[k]].count > cur)
                    cur = runs[ord[k]].base + runs[ord[k]].count;
            end
            if (lim > cur && lim - cur >= need) begin
                where = cur;
                return 1;
            end
            return 0;
        endfunction

        function void squeeze_runs();
            int ord[16];
            int n;
            int unsigned cur;
            order_runs(ord, n);
            cur = 0;
            for (int k = 0; k < n; k++) begin
                runs[ord[k]].base = cur;
                cur += runs[ord[k]].count;
            end
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                   logic [CNT_W-1:0] cnt, logic [IDX_W-1:0] idx);
            alloc_result_t r;
            int unsigned used, avail, where;
            int empty, slot;
            r.status = ST_OK;
            r.base_page = '0;
            r.physical_page = '0;
            r.compacted = 0;
            where = 0;
            if (cmd == CMD_ALLOC) begin
                used = 0;
                empty = -1;
                for (int i = 0; i < 16; i++)
                    if (runs[i].used) used += runs[i].count;
                    else if (empty < 0) empty = i;
                avail = area() > used ? area() - used : 0;
                if (cnt == 0) r.status = ST_BAD;
                else if (find_run(pid) >= 0) r.status = ST_DUPLICATE;
                else if (empty < 0) r.status = ST_BAD;
                else if (cnt > avail) r.status = ST_NO_SPACE;
                else begin
                    if (!fit_gap(cnt, where)) begin
                        squeeze_runs();
                        r.compacted = 1;
                        if (!fit_gap(cnt, where)) r.status = ST_NO_SPACE;
                    end
                    if (r.status == ST_OK) begin
                        runs[empty].used = 1;
                        runs[empty].pid = pid;
                        runs[empty].base = where;
                        runs[empty].count = cnt;
                        r.base_page = PAGE_W'(where);
                        if (r.compacted) compactions++;
                    end else
                        r.compacted = 0;
                end
            end else if (cmd == CMD_FREE || cmd == CMD_XLATE) begin
                slot = find_run(pid);
                if (slot < 0) r.status = ST_UNKNOWN;
                else if (cmd == CMD_FREE) begin
                    r.base_page = PAGE_W'(runs[slot].base);
                    runs[slot].used = 0;
                end else if (idx >= runs[slot].count) r.status = ST_RANGE;
                else begin
                    r.base_page = PAGE_W'(runs[slot].base);
                    r.physical_page = PAGE_W'(runs[slot].base + idx);
                end
            end else
                r.status = ST_BAD;
            pending.push_back(r);
        endfunction

        function void check_result(logic [STAT_W-1:0] st, logic [PAGE_W-1:0] bp,
                                   logic [PAGE_W-1:0] pp, logic cp);
            alloc_result_t e;
            results_seen++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d base=%0d", $time, st, bp);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (bp !== e.base_page) begin
                $display("%0t: base_page expected %0d actual %0d", $time, e.base_page, bp);
                errors++;
            end
            if (pp !== e.physical_page) begin
                $display("%0t: physical_page expected %0d actual %0d", $time,
                         e.physical_page, pp);
                errors++;
            end
            if (cp !== e.compacted) begin
                $display("%0t: compacted expected %0d actual %0d", $time, e.compacted, cp);
                errors++;
            end
        endfunction
    endclass
endpackage

// ===== sim/contiguous_page_allocator_tb.sv =====
// testbench top: drives the page allocator and checks every result beat
`timescale 1ns / 100ps
module contiguous_page_allocator_tb;
    import cpa_pkg::*;
    import cpa_sb_pkg::*;

    // command code the block does not know
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic clk = 0;
    logic rst_n = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    cpa_req_if req();
    cpa_rsp_if rsp();
    cpa_cfg_if cfg();

    alloc_scoreboard board = new();

    contiguous_page_allocator uut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    always #6 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.command = '0;
        req.process_id = '0;
        req.page_count = '0;
        req.page_index = '0;
        cfg.valid = 0;
        cfg.total_pages = '0;
        rsp.ready = 0;
    end

    // receiver: ready changes at falling edges, beats taken at rising edges
    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            board.check_result(rsp.status, rsp.base_page, rsp.physical_page, rsp.compacted);

    // called at a falling edge; valid stays up after the beat until the next
    // request or a drain lowers it, the block is busy meanwhile
    task automatic send_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                logic [CNT_W-1:0] cnt, logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 0;
            @(negedge clk);
        end
        req.valid <= 1;
        req.command <= cmd;
        req.process_id <= pid;
        req.page_count <= cnt;
        req.page_index <= idx;
        do @(posedge clk); while (!req.ready);
        board.note_request(cmd, pid, cnt, idx);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic write_total(logic [CNT_W-1:0] val);
        drain();
        cfg.valid <= 1;
        cfg.total_pages <= val;
        do @(posedge clk); while (!cfg.ready);
        board.total_pages = val;
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    // random content, mostly small runs over a pool of few process ids
    task automatic random_phase(int n, logic [CNT_W-1:0] cap);
        logic [CMD_W-1:0] cmd;
        logic [PID_W-1:0] pid;
        logic [CNT_W-1:0] cnt;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            cmd = r < 45 ? CMD_ALLOC : r < 75 ? CMD_FREE : r < 97 ? CMD_XLATE : CMD_UNUSED;
            pid = $urandom_range(99) < 90 ? PID_W'($urandom_range(19)) : PID_W'($urandom);
            if ($urandom_range(99) < 5) cnt = CNT_W'($urandom);
            else cnt = CNT_W'($urandom_range(cap));
            send_request(cmd, pid, cnt,
                         $urandom_range(99) < 70 ? IDX_W'($urandom_range(cap)) :
                         IDX_W'($urandom));
        end
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        // directed: extremes, every command, special cases
        send_request(CMD_ALLOC, 16'd1, 11'd0, '0);
        send_request(CMD_FREE, 16'hFFFF, '0, '0);
        send_request(CMD_XLATE, 16'hFFFF, '0, '0);
        send_request(CMD_UNUSED, 16'd5, 11'h7FF, 10'h3FF);
        send_request(CMD_ALLOC, 16'd1, 11'd2047, '0);
        send_request(CMD_ALLOC, 16'hFFFF, 11'd1024, '0);
        send_request(CMD_XLATE, 16'hFFFF, '0, 10'd1023);
        send_request(CMD_ALLOC, 16'd2, 11'd1, '0);
        send_request(CMD_FREE, 16'hFFFF, '0, '0);
        for (int i = 0; i < 16; i++)
            send_request(CMD_ALLOC, PID_W'(i + 10), 11'd60, '0);
        send_request(CMD_ALLOC, 16'd2, 11'd5, '0);
        send_request(CMD_XLATE, 16'd10, '0, 10'd60);
        send_request(CMD_XLATE, 16'd10, '0, 10'd59);
        for (int i = 0; i < 16; i += 2) send_request(CMD_FREE, PID_W'(i + 10), '0, '0);
        send_request(CMD_ALLOC, 16'd99, 11'd200, '0);
        write_total(11'd100);
        send_request(CMD_ALLOC, 16'd98, 11'd1, '0);
        send_request(CMD_XLATE, 16'd11, '0, 10'd3);
        for (int i = 0; i < 20; i++) send_request(CMD_FREE, PID_W'(i + 10), '0, '0);
        send_request(CMD_FREE, 16'd99, '0, '0);
        write_total(11'd0);
        send_request(CMD_ALLOC, 16'd3, 11'd1, '0);
        write_total(11'h7FF);
        send_request(CMD_ALLOC, 16'd3, 11'd1024, '0);
        send_request(CMD_FREE, 16'd3, '0, '0);
        write_total(11'd1);
        send_request(CMD_ALLOC, 16'd4, 11'd1, '0);
        send_request(CMD_FREE, 16'd4, '0, '0);
        // random phases across idling patterns and sizes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            case (ph)
                0: write_total(11'd1024);
                2: write_total(11'd150);
                4: write_total(11'd1);
                5: write_total(11'd2047);
                6: write_total(CNT_W'($urandom_range(200, 900)));
                default: ;
            endcase
            random_phase(67, ph == 5 ? 11'd300 : 11'd80);
        end
        drain();
        $display("covered %0d result beats, %0d compacting allocates, several area sizes",
                 board.results_seen, board.compactions);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
